// ===== rtl/slm_pkg.sv =====
`timescale 1ns / 1ps

package slm_pkg;

  localparam int unsigned ValueWidth       = 32;
  localparam int unsigned ListDepthDefault = 32;

  typedef enum logic [1:0] {
    OP_APPEND_FIRST  = 2'd0,
    OP_APPEND_SECOND = 2'd1,
    OP_MERGE         = 2'd2
  } op_e;

  typedef enum logic {
    ST_IDLE,
    ST_MERGE
  } state_e;

endpackage

// ===== rtl/slm_store.sv =====
`timescale 1ns / 1ps

module slm_store #(
  parameter int unsigned DEPTH  = slm_pkg::ListDepthDefault,
  parameter int unsigned ADDR_W = 5
) (
  input  logic                                clk_i,
  input  logic                                we_i,
  input  logic [ADDR_W-1:0]                   waddr_i,
  input  logic signed [slm_pkg::ValueWidth-1:0] wdata_i,
  input  logic [ADDR_W-1:0]                   raddr_i,
  output logic signed [slm_pkg::ValueWidth-1:0] rdata_o
);

  logic signed [slm_pkg::ValueWidth-1:0] mem [DEPTH];
  logic signed [slm_pkg::ValueWidth-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/sorted_list_merge.sv =====
`timescale 1ns / 1ps
// Channel   Dir  tdata          tuser      tlast
// s_axis    in   value[31:0]    op[1:0]    -
// m_axis    out  merged[31:0]   dropped    last
//
// An append beat writes one store entry, or sets the drop flag if that store is full.
// A merge beat with data stored emits the stored elements in turn; each store
// has one read port whose registered data holds the current head during a merge.
// Input is not taken while a merge is emitting; the last result sits in the
// output register while the next input beat is taken.
// Reset clears counts, read pointers, the drop flag and the output valid.

module sorted_list_merge #(
  parameter int unsigned LIST_DEPTH = slm_pkg::ListDepthDefault
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  input  logic signed [slm_pkg::ValueWidth-1:0] s_axis_tdata_i,   // value
  input  logic [1:0]                            s_axis_tuser_i,   // op
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  output logic signed [slm_pkg::ValueWidth-1:0] m_axis_tdata_o,   // merged_value
  output logic                                  m_axis_tlast_o,
  output logic                                  m_axis_tuser_o    // dropped
);

  localparam int unsigned CNT_W  = $clog2(LIST_DEPTH + 1);
  localparam int unsigned ADDR_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam logic [CNT_W-1:0] DepthCnt = CNT_W'(LIST_DEPTH);
  localparam logic [CNT_W-1:0] OneCnt   = CNT_W'(1);

  slm_pkg::state_e state_q, state_d;

  logic [CNT_W-1:0] cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic [CNT_W-1:0] ptr_a_q, ptr_a_d, ptr_b_q, ptr_b_d;
  logic             ovf_q, ovf_d;

  logic                                  out_valid_q, out_valid_d;
  logic signed [slm_pkg::ValueWidth-1:0] out_data_q, out_data_d;
  logic                                  out_last_q, out_last_d;
  logic                                  out_drop_q, out_drop_d;

  logic                                  in_fire, produce, pop_a, last_pick;
  logic                                  has_a, has_b, start_merge;
  logic                                  we_a, we_b;
  logic [CNT_W-1:0]                      ptr_a_nx, ptr_b_nx;
  logic [ADDR_W-1:0]                     raddr_a, raddr_b;
  logic signed [slm_pkg::ValueWidth-1:0] head_a, head_b;
  slm_pkg::op_e                          op;

  assign op      = slm_pkg::op_e'(s_axis_tuser_i);
  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;
  assign has_a   = ptr_a_q < cnt_a_q;
  assign has_b   = ptr_b_q < cnt_b_q;
  assign produce = (state_q == slm_pkg::ST_MERGE) && (!out_valid_q || m_axis_tready_i);

  always_comb begin
    if (has_a && has_b) begin
      pop_a = head_a < head_b;
    end else begin
      pop_a = has_a;
    end
  end

  assign ptr_a_nx  = ptr_a_q + CNT_W'(pop_a);
  assign ptr_b_nx  = ptr_b_q + CNT_W'(!pop_a);
  assign last_pick = (ptr_a_nx == cnt_a_q) && (ptr_b_nx == cnt_b_q);

  assign start_merge = in_fire && (op == slm_pkg::OP_MERGE) &&
                       ((cnt_a_q != '0) || (cnt_b_q != '0));

  assign raddr_a = (produce && pop_a)  ? ptr_a_nx[ADDR_W-1:0] : ptr_a_q[ADDR_W-1:0];
  assign raddr_b = (produce && !pop_a) ? ptr_b_nx[ADDR_W-1:0] : ptr_b_q[ADDR_W-1:0];

  assign we_a = in_fire && (op == slm_pkg::OP_APPEND_FIRST)  && (cnt_a_q < DepthCnt);
  assign we_b = in_fire && (op == slm_pkg::OP_APPEND_SECOND) && (cnt_b_q < DepthCnt);

  slm_store #(
    .DEPTH  (LIST_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (cnt_a_q[ADDR_W-1:0]),
    .wdata_i (s_axis_tdata_i),
    .raddr_i (raddr_a),
    .rdata_o (head_a)
  );

  slm_store #(
    .DEPTH  (LIST_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (cnt_b_q[ADDR_W-1:0]),
    .wdata_i (s_axis_tdata_i),
    .raddr_i (raddr_b),
    .rdata_o (head_b)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      slm_pkg::ST_IDLE: begin
        if (start_merge) begin
          state_d = slm_pkg::ST_MERGE;
        end
      end
      slm_pkg::ST_MERGE: begin
        if (produce && last_pick) begin
          state_d = slm_pkg::ST_IDLE;
        end
      end
      default: state_d = slm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready_o = 1'b0;
    case (state_q)
      slm_pkg::ST_IDLE:  s_axis_tready_o = 1'b1;
      slm_pkg::ST_MERGE: s_axis_tready_o = 1'b0;
      default:           s_axis_tready_o = 1'b0;
    endcase
  end

  always_comb begin
    cnt_a_d = cnt_a_q;
    cnt_b_d = cnt_b_q;
    ptr_a_d = ptr_a_q;
    ptr_b_d = ptr_b_q;
    ovf_d   = ovf_q;
    if (in_fire) begin
      case (op)
        slm_pkg::OP_APPEND_FIRST: begin
          if (we_a) begin
            cnt_a_d = cnt_a_q + OneCnt;
          end else begin
            ovf_d = 1'b1;
          end
        end
        slm_pkg::OP_APPEND_SECOND: begin
          if (we_b) begin
            cnt_b_d = cnt_b_q + OneCnt;
          end else begin
            ovf_d = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    if (produce) begin
      if (last_pick) begin
        cnt_a_d = '0;
        cnt_b_d = '0;
        ptr_a_d = '0;
        ptr_b_d = '0;
      end else begin
        ptr_a_d = ptr_a_nx;
        ptr_b_d = ptr_b_nx;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    out_drop_d  = out_drop_q;
    if (produce) begin
      out_valid_d = 1'b1;
      out_data_d  = pop_a ? head_a : head_b;
      out_last_d  = last_pick;
      out_drop_d  = ovf_q;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= slm_pkg::ST_IDLE;
      cnt_a_q     <= '0;
      cnt_b_q     <= '0;
      ptr_a_q     <= '0;
      ptr_b_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_a_q     <= cnt_a_d;
      cnt_b_q     <= cnt_b_d;
      ptr_a_q     <= ptr_a_d;
      ptr_b_q     <= ptr_b_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
    out_drop_q <= out_drop_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_drop_q;

endmodule
